[hw/rtl/qir_pkg.sv]
// Shared types, constants and constant functions of the quaternion integration residual block.
`timescale 1ns / 1ps

package qir_pkg;

    // CORDIC depth; must lie in 16..48.
    localparam int CORDIC_ITERATIONS = 32;

    // Quotient bits of the sin(theta)*omega/|omega| divider.
    localparam int QUO_W = 31;

    // Queue between the front and back parts; a power of two.
    localparam int QUEUE_DEPTH = 4;

    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_SQUARE_MODE = 1'd0;

    localparam int RES_W = 36;

    localparam logic signed [63:0] PI4_Q62         = 64'sh3243F6A8885A308D;
    localparam logic [62:0]        PIO2_Q62        = 63'h6487ED5110B4611A;
    localparam logic [63:0]        TWO_OVER_PI_Q64 = 64'hA2F9836E4E44152A;
    localparam logic signed [63:0] GAIN_Q62        = 64'sd2800459870029452954;
    localparam logic signed [31:0] ONE_Q30         = 32'sd1073741824;
    localparam logic signed [RES_W-1:0] RES_MAX    = 36'sh7FFFFFFFF;
    localparam logic signed [RES_W-1:0] RES_MIN    = 36'sh800000000;

    // Payload carried through the norm pipeline of the front part.
    typedef struct packed {
        logic [3:0][31:0] q1;
        logic [3:0][31:0] q2;
        logic [2:0][31:0] w;
        logic [31:0]      h;
    } t_in_carry;

    // One classified item as handed from the front part to the back part.
    typedef struct packed {
        logic [3:0][31:0] q1;
        logic [3:0][31:0] q2;
        logic [2:0][31:0] w;
        logic [31:0]      n;
        logic [63:0]      p;
        logic             zero;
    } t_front_item;

    // Payload carried alongside the trig and divider pipelines.
    typedef struct packed {
        logic [3:0][31:0] q1;
        logic [3:0][31:0] q2;
        logic [2:0][31:0] w;
        logic [31:0]      n;
        logic             zero;
    } t_back_carry;

    // Arctangent of 2^-i in Q.62: pi/4 for i = 0, else the truncated
    // alternating series. Evaluated only at elaboration; the quotients use
    // a shift-and-subtract loop.
    function automatic logic signed [63:0] atan_q62(input int i);
        logic signed [63:0] acc;
        logic [63:0]        num;
        logic [63:0]        quo;
        logic [63:0]        rem;
        logic [63:0]        dvs;
        int                 k;
        int                 e;
        int                 b;
        acc = '0;
        if (i == 0) begin
            acc = PI4_Q62;
        end else begin
            for (k = 0; k < 32; k++) begin
                e = i * (2 * k + 1);
                if (e <= 62) begin
                    num = 64'd1 << (62 - e);
                    dvs = 64'(2 * k + 1);
                    quo = '0;
                    rem = '0;
                    for (b = 63; b >= 0; b--) begin
                        rem = {rem[62:0], num[b]};
                        quo = {quo[62:0], 1'b0};
                        if (rem >= dvs) begin
                            rem    = rem - dvs;
                            quo[0] = 1'b1;
                        end
                    end
                    if (k[0]) begin
                        acc = acc - $signed(quo);
                    end else begin
                        acc = acc + $signed(quo);
                    end
                end
            end
        end
        return acc;
    endfunction

endpackage

[hw/rtl/qir_if.sv]
// Stream interfaces for the input and result beats of the residual block.
`timescale 1ns / 1ps

interface qir_in_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] q1_w;
    logic signed [31:0] q1_x;
    logic signed [31:0] q1_y;
    logic signed [31:0] q1_z;
    logic signed [31:0] q2_w;
    logic signed [31:0] q2_x;
    logic signed [31:0] q2_y;
    logic signed [31:0] q2_z;
    logic signed [31:0] omega_x;
    logic signed [31:0] omega_y;
    logic signed [31:0] omega_z;
    logic [31:0]        time_step;

    modport source (
        output valid, q1_w, q1_x, q1_y, q1_z, q2_w, q2_x, q2_y, q2_z,
               omega_x, omega_y, omega_z, time_step,
        input  ready
    );
    modport sink (
        input  valid, q1_w, q1_x, q1_y, q1_z, q2_w, q2_x, q2_y, q2_z,
               omega_x, omega_y, omega_z, time_step,
        output ready
    );
endinterface

interface qir_out_if;
    logic               valid;
    logic               ready;
    logic signed [35:0] residual;
    logic               saturated;

    modport source (output valid, residual, saturated, input ready);
    modport sink (input valid, residual, saturated, output ready);
endinterface

[hw/rtl/quaternion_integration_residual.sv]
// Top level of the quaternion integration residual block with its APB register.
// Throughput: one beat per cycle while the result side is not stalled; the front norm
// pipeline, the queue and the fully pipelined CORDIC, divider and multiplier stages of
// the back part each take one per cycle.
// Reset: synchronous, active low; clears all valid bits, the queue and square_mode.
`timescale 1ns / 1ps

module quaternion_integration_residual (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    qir_in_if.sink                           i_in,
    qir_out_if.source                        o_out,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [qir_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [qir_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [qir_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import qir_pkg::*;

    // The front part computes |omega| with a one-bit-per-stage square root, forms the
    // angle product and marks items with zero rate. The back part reduces the angle to
    // a quadrant, rotates with the CORDIC, divides out |omega| and forms the Hamilton and
    // dot products. The queue between them lets the front keep taking beats while the
    // result side is stalled.

    logic        r_square_mode;
    logic        w_cfg_wr;
    logic        w_reg_hit;
    t_front_item w_front_item;
    logic        w_front_valid;
    logic        w_front_ready;
    t_front_item w_queue_item;
    logic        w_queue_valid;
    logic        w_back_ready;

    // Configuration register: one bit at byte address 0.
    assign pready    = 1'b1;
    assign w_reg_hit = (paddr[APB_ADDR_W-1:2] == REG_SQUARE_MODE);
    assign w_cfg_wr  = psel && penable && pwrite && pready && w_reg_hit;
    assign prdata    = w_reg_hit ? {{(APB_DATA_W-1){1'b0}}, r_square_mode} : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_square_mode <= 1'b0;
        end else if (w_cfg_wr) begin
            r_square_mode <= pwdata[0];
        end
    end

    qir_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_in    (i_in),
        .o_item  (w_front_item),
        .o_valid (w_front_valid),
        .i_ready (w_front_ready)
    );

    qir_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (w_front_item),
        .i_valid (w_front_valid),
        .o_ready (w_front_ready),
        .o_item  (w_queue_item),
        .o_valid (w_queue_valid),
        .i_ready (w_back_ready)
    );

    // User changes square_mode only while the block is idle, unchecked; read live.
    qir_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item        (w_queue_item),
        .i_valid       (w_queue_valid),
        .o_ready       (w_back_ready),
        .i_square_mode (r_square_mode),
        .m_out         (o_out)
    );

    // A clipped result always sits exactly on one of the two bounds.
    a_sat_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.saturated) |->
            (o_out.residual == RES_MAX || o_out.residual == RES_MIN))
        else $error("saturated result beat not on a bound");

    // A stalled result beat freezes the back pipeline, so the queue must not pop.
    a_back_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.ready) |-> !w_back_ready)
        else $error("back part took an item while its result beat was stalled");

    // A register write lands in square_mode on the next cycle.
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cfg_wr |=> (r_square_mode == $past(pwdata[0])))
        else $error("square_mode write was lost");

endmodule

[hw/rtl/qir_front.sv]
// Front part: accepts beats, forms the rate norm and the angle product, flags zero rate.
`timescale 1ns / 1ps

module qir_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    qir_in_if.sink             s_in,
    output qir_pkg::t_front_item o_item,
    output logic               o_valid,
    input  logic               i_ready
);
    import qir_pkg::*;

    localparam int SQ_STEPS = 32;
    localparam int LAST     = SQ_STEPS + 2;

    logic [LAST:0]    r_vld;
    logic             w_en;
    t_in_carry        r_cq [0:LAST-1];
    logic [2:0][63:0] r_sq;
    logic [63:0]      r_sum;
    logic [63:0]      r_rem  [0:SQ_STEPS-1];
    logic [63:0]      r_root [0:SQ_STEPS-1];
    logic [31:0]      w_n;
    logic [63:0]      w_p;
    t_front_item      r_out;

    // The whole pipe advances together unless its last stage is blocked.
    assign w_en       = !r_vld[LAST] || i_ready;
    assign s_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[LAST-1:0], s_in.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cq[0].q1 <= {s_in.q1_z, s_in.q1_y, s_in.q1_x, s_in.q1_w};
            r_cq[0].q2 <= {s_in.q2_z, s_in.q2_y, s_in.q2_x, s_in.q2_w};
            r_cq[0].w  <= {s_in.omega_z, s_in.omega_y, s_in.omega_x};
            r_cq[0].h  <= s_in.time_step;
            r_sq[0]    <= s_in.omega_x * s_in.omega_x;
            r_sq[1]    <= s_in.omega_y * s_in.omega_y;
            r_sq[2]    <= s_in.omega_z * s_in.omega_z;
            r_sum      <= r_sq[0] + r_sq[1] + r_sq[2];
            r_cq[1]    <= r_cq[0];
        end
    end

    // Digit-by-digit square root, one result bit per stage.
    for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * g);
        logic [63:0] v_in;
        logic [63:0] r_in;
        logic [64:0] t;
        logic        ge;
        if (g == 0) begin : g_first
            assign v_in = r_sum;
            assign r_in = '0;
        end else begin : g_next
            assign v_in = r_rem[g-1];
            assign r_in = r_root[g-1];
        end
        assign t  = {1'b0, r_in} + {1'b0, BIT};
        assign ge = ({1'b0, v_in} >= t);
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rem[g]    <= ge ? (v_in - t[63:0]) : v_in;
                r_root[g]   <= ge ? ((r_in >> 1) + BIT) : (r_in >> 1);
                r_cq[2 + g] <= r_cq[1 + g];
            end
        end
    end

    assign w_n = r_root[SQ_STEPS-1][31:0];
    assign w_p = w_n * r_cq[LAST-1].h;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out.q1   <= r_cq[LAST-1].q1;
            r_out.q2   <= r_cq[LAST-1].q2;
            r_out.w    <= r_cq[LAST-1].w;
            r_out.n    <= w_n;
            r_out.p    <= w_p;
            r_out.zero <= (w_n == '0);
        end
    end

    assign o_item  = r_out;
    assign o_valid = r_vld[LAST];

endmodule

[hw/rtl/qir_queue.sv]
// Short queue of classified items between the front and back parts.
`timescale 1ns / 1ps

module qir_queue (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  qir_pkg::t_front_item i_item,
    input  logic                 i_valid,
    output logic                 o_ready,
    output qir_pkg::t_front_item o_item,
    output logic                 o_valid,
    input  logic                 i_ready
);
    import qir_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_front_item      r_mem [0:QUEUE_DEPTH-1];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [PTR_W:0]   r_cnt;
    logic             w_push;
    logic             w_pop;

    assign o_ready = (r_cnt != (PTR_W + 1)'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;
    assign o_item  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (w_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

endmodule

[hw/rtl/qir_back.sv]
// Back part: range reduction, CORDIC, divider, Hamilton product, dot product, optional squaring and saturation.
`timescale 1ns / 1ps

module qir_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  qir_pkg::t_front_item i_item,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic                 i_square_mode,
    qir_out_if.source            m_out
);
    import qir_pkg::*;

    localparam int N       = CORDIC_ITERATIONS;
    localparam int ST_RED  = 1;
    localparam int ST_PP2  = 2;
    localparam int ST_ANG  = 3;
    localparam int ST_CRD  = 4;
    localparam int ST_QUAD = ST_CRD + N;
    localparam int ST_MUL  = ST_QUAD + 1;
    localparam int ST_ABS  = ST_MUL + 1;
    localparam int ST_DIV  = ST_ABS + 1;
    localparam int ST_DZ   = ST_DIV + QUO_W;
    localparam int ST_HP   = ST_DZ + 1;
    localparam int ST_HS   = ST_HP + 1;
    localparam int ST_DP   = ST_HS + 1;
    localparam int ST_DS   = ST_DP + 1;
    localparam int ST_SA   = ST_DS + 1;
    localparam int ST_SP   = ST_SA + 1;
    localparam int ST_OUT  = ST_SP + 1;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    logic [ST_OUT:0]    r_vld;
    logic               w_en;
    t_back_carry        r_cq [0:ST_HS];

    logic [3:0][63:0]   r_pp1;
    logic [127:0]       w_prod1;
    logic [1:0]         r_quad;
    logic [61:0]        r_frac;
    logic [3:0][63:0]   r_pp2;
    logic [1:0]         r_quad2;
    logic [127:0]       w_prod2;
    logic signed [63:0] r_z0;
    logic [1:0]         r_quad3;

    logic signed [63:0] r_x [0:N-1];
    logic signed [63:0] r_y [0:N-1];
    logic signed [63:0] r_z [0:N-1];
    logic [1:0]         r_qd [0:N-1];

    logic signed [63:0] w_c;
    logic signed [63:0] w_s;
    logic signed [31:0] r_c30;
    logic signed [31:0] r_s30;
    logic signed [63:0] r_prod [0:2];
    logic signed [31:0] r_cmul;
    logic [2:0][62:0]   r_mag;
    logic [2:0]         r_neg;
    logic signed [31:0] r_cabs;

    logic [2:0][62:0]   r_rem  [0:QUO_W-1];
    logic [2:0][QUO_W-1:0] r_quo [0:QUO_W-1];
    logic [2:0]         r_dneg [0:QUO_W-1];
    logic signed [31:0] r_dcos [0:QUO_W-1];

    logic signed [31:0] r_d [0:3];
    logic signed [63:0] r_hp [0:3][0:3];
    logic signed [63:0] w_s4 [0:3][0:3];
    logic signed [63:0] w_psum [0:3];
    logic signed [35:0] r_p [0:3];
    logic signed [67:0] r_dp [0:3];
    logic signed [67:0] w_dsum;
    logic signed [39:0] r_dot;
    logic signed [39:0] r_dot_a;
    logic [39:0]        r_dmag;
    logic signed [39:0] r_dot_p;
    logic [63:0]        r_sll;
    logic [39:0]        r_slh;
    logic [15:0]        r_shh;
    logic [79:0]        w_m2;
    logic [4:0]         w_hi;
    logic signed [RES_W-1:0] r_res;
    logic               r_sat;

    assign w_en    = !r_vld[ST_OUT] || m_out.ready;
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[ST_OUT-1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cq[0].q1   <= i_item.q1;
            r_cq[0].q2   <= i_item.q2;
            r_cq[0].w    <= i_item.w;
            r_cq[0].n    <= i_item.n;
            r_cq[0].zero <= i_item.zero;
            for (int k = 1; k <= ST_HS; k++) begin
                r_cq[k] <= r_cq[k-1];
            end
        end
    end

    // Range reduction: angle times 2/pi, split into 32-bit partial products.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pp1[0] <= i_item.p[31:0]  * TWO_OVER_PI_Q64[31:0];
            r_pp1[1] <= i_item.p[31:0]  * TWO_OVER_PI_Q64[63:32];
            r_pp1[2] <= i_item.p[63:32] * TWO_OVER_PI_Q64[31:0];
            r_pp1[3] <= i_item.p[63:32] * TWO_OVER_PI_Q64[63:32];
        end
    end

    assign w_prod1 = {64'b0, r_pp1[0]} + {32'b0, r_pp1[1], 32'b0}
                   + {32'b0, r_pp1[2], 32'b0} + {r_pp1[3], 64'b0};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_quad <= w_prod1[114:113];
            r_frac <= w_prod1[112:51];
        end
    end

    // Fraction of a quadrant back to radians in Q.62.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pp2[0] <= r_frac[31:0] * PIO2_Q62[31:0];
            r_pp2[1] <= r_frac[31:0] * PIO2_Q62[62:32];
            r_pp2[2] <= r_frac[61:32] * PIO2_Q62[31:0];
            r_pp2[3] <= r_frac[61:32] * PIO2_Q62[62:32];
            r_quad2  <= r_quad;
        end
    end

    assign w_prod2 = {64'b0, r_pp2[0]} + {32'b0, r_pp2[1], 32'b0}
                   + {32'b0, r_pp2[2], 32'b0} + {r_pp2[3], 64'b0};

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_z0    <= $signed({1'b0, w_prod2[124:62]});
            r_quad3 <= r_quad2;
        end
    end

    // CORDIC rotation, one micro-rotation per stage.
    for (genvar g = 0; g < N; g++) begin : g_crd
        localparam logic signed [63:0] ANG = atan_q62(g);
        logic signed [63:0] x_in;
        logic signed [63:0] y_in;
        logic signed [63:0] z_in;
        logic [1:0]         q_in;
        if (g == 0) begin : g_first
            assign x_in = GAIN_Q62;
            assign y_in = '0;
            assign z_in = r_z0;
            assign q_in = r_quad3;
        end else begin : g_next
            assign x_in = r_x[g-1];
            assign y_in = r_y[g-1];
            assign z_in = r_z[g-1];
            assign q_in = r_qd[g-1];
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (!z_in[63]) begin
                    r_x[g] <= x_in - (y_in >>> g);
                    r_y[g] <= y_in + (x_in >>> g);
                    r_z[g] <= z_in - ANG;
                end else begin
                    r_x[g] <= x_in + (y_in >>> g);
                    r_y[g] <= y_in - (x_in >>> g);
                    r_z[g] <= z_in + ANG;
                end
                r_qd[g] <= q_in;
            end
        end
    end

    always_comb begin
        unique case (r_qd[N-1])
            QUAD_0: begin
                w_c = r_x[N-1];
                w_s = r_y[N-1];
            end
            QUAD_1: begin
                w_c = -r_y[N-1];
                w_s = r_x[N-1];
            end
            QUAD_2: begin
                w_c = -r_x[N-1];
                w_s = -r_y[N-1];
            end
            QUAD_3: begin
                w_c = r_y[N-1];
                w_s = -r_x[N-1];
            end
            default: begin
                w_c = r_x[N-1];
                w_s = r_y[N-1];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c30 <= w_c[63:32];
            r_s30 <= w_s[63:32];
            for (int i = 0; i < 3; i++) begin
                r_prod[i] <= $signed(r_cq[ST_QUAD].w[i]) * r_s30;
            end
            r_cmul <= r_c30;
            for (int i = 0; i < 3; i++) begin
                r_mag[i] <= r_prod[i][63] ? 63'(-r_prod[i]) : r_prod[i][62:0];
                r_neg[i] <= r_prod[i][63];
            end
            r_cabs <= r_cmul;
        end
    end

    // Restoring divider for omega*sin/|omega|, one quotient bit per stage.
    for (genvar j = 0; j < QUO_W; j++) begin : g_div
        logic [2:0][62:0]      rem_in;
        logic [2:0][QUO_W-1:0] quo_in;
        logic [2:0]            neg_in;
        logic signed [31:0]    cos_in;
        logic [62:0]           dvs;
        if (j == 0) begin : g_first
            assign rem_in = r_mag;
            assign quo_in = '0;
            assign neg_in = r_neg;
            assign cos_in = r_cabs;
        end else begin : g_next
            assign rem_in = r_rem[j-1];
            assign quo_in = r_quo[j-1];
            assign neg_in = r_dneg[j-1];
            assign cos_in = r_dcos[j-1];
        end
        assign dvs = {31'b0, r_cq[ST_DIV+j-1].n} << (QUO_W - 1 - j);
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                for (int i = 0; i < 3; i++) begin
                    if (rem_in[i] >= dvs) begin
                        r_rem[j][i] <= rem_in[i] - dvs;
                        r_quo[j][i] <= {quo_in[i][QUO_W-2:0], 1'b1};
                    end else begin
                        r_rem[j][i] <= rem_in[i];
                        r_quo[j][i] <= {quo_in[i][QUO_W-2:0], 1'b0};
                    end
                end
                r_dneg[j] <= neg_in;
                r_dcos[j] <= cos_in;
            end
        end
    end

    // Rotation increment; zero rate gives the identity.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_d[0] <= r_cq[ST_DZ-1].zero ? ONE_Q30 : r_dcos[QUO_W-1];
            for (int i = 0; i < 3; i++) begin
                if (r_cq[ST_DZ-1].zero) begin
                    r_d[i+1] <= '0;
                end else if (r_dneg[QUO_W-1][i]) begin
                    r_d[i+1] <= -$signed({1'b0, r_quo[QUO_W-1][i]});
                end else begin
                    r_d[i+1] <= $signed({1'b0, r_quo[QUO_W-1][i]});
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                for (int m = 0; m < 4; m++) begin
                    r_hp[k][m] <= r_d[k] * $signed(r_cq[ST_DZ].q1[m]);
                end
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            for (int m = 0; m < 4; m++) begin
                w_s4[k][m] = r_hp[k][m] >>> 4;
            end
        end
        w_psum[0] = w_s4[0][0] - w_s4[1][1] - w_s4[2][2] - w_s4[3][3];
        w_psum[1] = w_s4[0][1] + w_s4[1][0] + w_s4[2][3] - w_s4[3][2];
        w_psum[2] = w_s4[0][2] - w_s4[1][3] + w_s4[2][0] + w_s4[3][1];
        w_psum[3] = w_s4[0][3] + w_s4[1][2] - w_s4[2][1] + w_s4[3][0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 4; i++) begin
                r_p[i]  <= 36'(w_psum[i] >>> 28);
                r_dp[i] <= $signed(r_cq[ST_HS].q2[i]) * r_p[i];
            end
        end
    end

    assign w_dsum = (r_dp[0] >>> 2) + (r_dp[1] >>> 2) + (r_dp[2] >>> 2) + (r_dp[3] >>> 2);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dot   <= 40'(w_dsum >>> 26);
            r_dot_a <= r_dot;
            r_dmag  <= r_dot[39] ? 40'(-r_dot) : r_dot;
            r_sll   <= r_dmag[31:0] * r_dmag[31:0];
            r_slh   <= r_dmag[31:0] * r_dmag[39:32];
            r_shh   <= r_dmag[39:32] * r_dmag[39:32];
            r_dot_p <= r_dot_a;
        end
    end

    // Square as three partial products; anything at or above 2^65 clips.
    assign w_m2 = {16'b0, r_sll} + ({40'b0, r_slh} << 33) + {r_shh, 64'b0};
    assign w_hi = r_dot_p[39:35];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (i_square_mode) begin
                if (w_m2[79:65] != '0) begin
                    r_res <= RES_MAX;
                    r_sat <= 1'b1;
                end else begin
                    r_res <= $signed({1'b0, w_m2[64:30]});
                    r_sat <= 1'b0;
                end
            end else if (w_hi == '0 || w_hi == '1) begin
                r_res <= r_dot_p[35:0];
                r_sat <= 1'b0;
            end else begin
                r_res <= r_dot_p[39] ? RES_MIN : RES_MAX;
                r_sat <= 1'b1;
            end
        end
    end

    assign m_out.valid     = r_vld[ST_OUT];
    assign m_out.residual  = r_res;
    assign m_out.saturated = r_sat;

endmodule
